/* hdl/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types, constants and character helpers for the integer to ascii
// formatter
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_W    = 64;
    localparam int LOW_W      = 32;
    localparam int CMD_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int NIBBLE_W   = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * NIBBLE_W;
    localparam int HEX_DIGITS = VALUE_W / NIBBLE_W;
    localparam int NDIG_W     = $clog2(HEX_DIGITS + 1);
    localparam int BITCNT_W   = $clog2(LOW_W + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [CMD_W-1:0] {
        CMD_SDEC = 3'd0,
        CMD_UDEC = 3'd1,
        CMD_HEXL = 3'd2,
        CMD_HEXU = 3'd3,
        CMD_PTR  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // one digit to its ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIBBLE_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] c;
        begin
            if (d < 4'd10) begin
                c = CHAR_ZERO + {4'd0, d};
            end else if (upper) begin
                c = 8'h41 + {4'd0, d - 4'd10};
            end else begin
                c = 8'h61 + {4'd0, d - 4'd10};
            end
            return c;
        end
    endfunction

endpackage

/* hdl/i2a_dabble.sv */
// ----------------------------------------------------------------------------
// i2a_dabble
// one shift-add-3 step of the binary to bcd conversion
// ----------------------------------------------------------------------------
module i2a_dabble
    import i2a_pkg::*;
(
    input  logic [BCD_W-1:0] bcd_in,
    input  logic             bit_in,
    output logic [BCD_W-1:0] bcd_out
);

    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_in[i*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
                adj[i*NIBBLE_W +: NIBBLE_W] = bcd_in[i*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end else begin
                adj[i*NIBBLE_W +: NIBBLE_W] = bcd_in[i*NIBBLE_W +: NIBBLE_W];
            end
        end
    end

    assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule

/* hdl/integer_to_ascii_formatter_core.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// formats a binary value as decimal, hex or pointer text, one character a word
// ----------------------------------------------------------------------------
// decimal runs the bcd conversion on the low 32 bits, then drops up to 9 leading
//   zero digits and emits the characters; hex and pointer skip the conversion
// one item at a time: a new item is accepted only back in idle, after the last
//   character is loaded; a reserved command is dropped without output
// reset: synchronous active-low aresetn clears the sequencer, output valid and
//   the running character count
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
    import i2a_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [VALUE_W-1:0]        s_tdata,  // value[63:0]
    input  logic [CMD_W-1:0]          s_tuser,  // cmd[2:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [COUNT_W+CHAR_W-1:0] m_tdata,  // char_out[7:0], total_count[39:8]
    output logic                      m_tlast
);

    state_t                    state_reg, state_next;
    logic [VALUE_W-1:0]        dig_reg, dig_next;
    logic [LOW_W-1:0]          bin_reg, bin_next;
    logic [BITCNT_W-1:0]       bitcnt_reg, bitcnt_next;
    logic [NDIG_W-1:0]         ndig_reg, ndig_next;
    logic [1:0]                pre_reg, pre_next;
    logic                      ptr_reg, ptr_next;
    logic                      upper_reg, upper_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W+CHAR_W-1:0] m_tdata_reg, m_tdata_next;
    logic                      m_tlast_reg, m_tlast_next;

    logic [LOW_W-1:0]  low;
    logic [LOW_W-1:0]  neg_low;
    logic [BCD_W-1:0]  bcd_step;
    logic              out_free;
    logic              out_load;
    logic [CHAR_W-1:0] pre_char;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;

    assign low     = s_tdata[LOW_W-1:0];
    assign neg_low = ~low + 32'd1;

    i2a_dabble u_dabble (
        .bcd_in  (dig_reg[VALUE_W-1 -: BCD_W]),
        .bit_in  (bin_reg[LOW_W-1]),
        .bcd_out (bcd_step)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        if (ptr_reg) begin
            pre_char = (pre_reg == 2'd2) ? CHAR_ZERO : CHAR_X;
        end else begin
            pre_char = CHAR_MINUS;
        end
        out_char = (pre_reg != 2'd0) ? pre_char
                                      : digit_char(dig_reg[VALUE_W-1 -: NIBBLE_W], upper_reg);
        out_last = (pre_reg == 2'd0) && (ndig_reg == NDIG_W'(1));
    end

    always_comb begin
        state_next    = state_reg;
        dig_next      = dig_reg;
        bin_next      = bin_reg;
        bitcnt_next   = bitcnt_reg;
        ndig_next     = ndig_reg;
        pre_next      = pre_reg;
        ptr_next      = ptr_reg;
        upper_next    = upper_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pre_next   = 2'd0;
                    ptr_next   = 1'b0;
                    upper_next = 1'b0;
                    case (s_tuser)
                        CMD_SDEC, CMD_UDEC: begin
                            dig_next    = '0;
                            bitcnt_next = BITCNT_W'(LOW_W);
                            if (s_tuser == CMD_SDEC && low[LOW_W-1]) begin
                                bin_next = neg_low;
                                pre_next = 2'd1;
                            end else begin
                                bin_next = low;
                            end
                            state_next = ST_CONV;
                        end
                        CMD_HEXL, CMD_HEXU: begin
                            dig_next   = {low, {(VALUE_W-LOW_W){1'b0}}};
                            ndig_next  = NDIG_W'(LOW_W / NIBBLE_W);
                            upper_next = (s_tuser == CMD_HEXU);
                            state_next = ST_SKIP;
                        end
                        CMD_PTR: begin
                            dig_next   = s_tdata;
                            ndig_next  = NDIG_W'(HEX_DIGITS);
                            pre_next   = 2'd2;
                            ptr_next   = 1'b1;
                            state_next = ST_SKIP;
                        end
                        default: begin
                            // undefined command: dropped without output
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                dig_next    = {bcd_step, {(VALUE_W-BCD_W){1'b0}}};
                bin_next    = {bin_reg[LOW_W-2:0], 1'b0};
                bitcnt_next = bitcnt_reg - BITCNT_W'(1);
                if (bitcnt_reg == BITCNT_W'(1)) begin
                    ndig_next  = NDIG_W'(BCD_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zero digits, keeping at least one
                if (dig_reg[VALUE_W-1 -: NIBBLE_W] == 4'd0 && ndig_reg > NDIG_W'(1)) begin
                    dig_next  = {dig_reg[VALUE_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    count_next    = count_reg + 32'd1;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {count_reg + 32'd1, out_char};
                    m_tlast_next  = out_last;
                    if (pre_reg != 2'd0) begin
                        pre_next = pre_reg - 2'd1;
                    end else begin
                        dig_next  = {dig_reg[VALUE_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                        ndig_next = ndig_reg - NDIG_W'(1);
                        if (out_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            bitcnt_reg   <= '0;
            ndig_reg     <= '0;
            pre_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            bitcnt_reg   <= bitcnt_next;
            ndig_reg     <= ndig_next;
            pre_reg      <= pre_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg     <= dig_next;
        bin_reg     <= bin_next;
        ptr_reg     <= ptr_next;
        upper_reg   <= upper_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // each word loaded carries the count advanced by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_tdata_reg[COUNT_W+CHAR_W-1:CHAR_W] == count_reg))
        else $error("word count does not match running count");

    // no character is emitted with no digits left
    a_emit_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (ndig_reg != '0))
        else $error("emit state entered with no digits");

    // conversion always finishes and hands a full bcd word to the zero skip
    a_conv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && bitcnt_reg == BITCNT_W'(1))
        |=> (state_reg == ST_SKIP && ndig_reg == NDIG_W'(BCD_DIGITS)))
        else $error("bcd conversion did not complete");

endmodule
